### sv/date_keyed_sorted_table_assert.svh
// Assertion macros for the date-keyed sorted table.
`ifndef DATE_KEYED_SORTED_TABLE_ASSERT_SVH
`define DATE_KEYED_SORTED_TABLE_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, sampled on clk, off during reset.
`define DKST_ASSERT_IMP(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, sampled on clk, off during reset.
`define DKST_ASSERT_NXT(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error("assertion failed");
`else
`define DKST_ASSERT_IMP(lbl, ant, cons)
`define DKST_ASSERT_NXT(lbl, ant, cons)
`endif
`endif

### sv/dkst_pkg.sv
// Shared constants and types of the date-keyed sorted table.
package dkst_pkg;

    localparam int YEAR_W = 14;
    localparam int MON_W  = 4;
    localparam int DAY_W  = 5;
    localparam int KEY_W  = YEAR_W + MON_W + DAY_W;
    localparam int OUT_HANDLE_W = 16;

    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_LIST   = 2'd1;
    localparam logic [1:0] KIND_SHOW   = 2'd2;
    localparam logic [1:0] KIND_REMOVE = 2'd3;

    localparam logic [3:0] ST_INSERTED = 4'd0;
    localparam logic [3:0] ST_REPLACED = 4'd1;
    localparam logic [3:0] ST_FOUND    = 4'd2;
    localparam logic [3:0] ST_NOTFOUND = 4'd3;
    localparam logic [3:0] ST_REMOVED  = 4'd4;
    localparam logic [3:0] ST_ILLEGAL  = 4'd5;
    localparam logic [3:0] ST_FULL     = 4'd6;
    localparam logic [3:0] ST_ENTRY    = 4'd7;
    localparam logic [3:0] ST_EMPTY    = 4'd8;

    // Reciprocal of 100 in Q19, exact for every 14-bit year
    localparam logic [12:0] RECIP_100 = 13'd5243;

    typedef struct packed {
        logic done;
        logic legal;
    } dkst_chk_t;

endpackage

### sv/dkst_mem.sv
// Single-port-write, registered-read record memory.
module dkst_mem #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 39,
    parameter int AW    = 5
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/dkst_date_check.sv
// Two-stage Gregorian date legality check.
module dkst_date_check (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [dkst_pkg::KEY_W-1:0] key,
    output dkst_pkg::dkst_chk_t       chk
);
    import dkst_pkg::*;

    logic              v1_reg;
    logic [YEAR_W-1:0] y1_reg;
    logic [MON_W-1:0]  m1_reg;
    logic [DAY_W-1:0]  d1_reg;
    logic [7:0]        q1_reg;
    logic              done_reg;
    logic              legal_reg;

    logic [26:0]       prod;
    logic [14:0]       q_x100;
    logic [14:0]       rem;
    logic              leap;
    logic              legal_next;

    assign prod = {13'd0, key[KEY_W-1 -: YEAR_W]} * {14'd0, RECIP_100};

    always_comb
    begin
        q_x100 = {7'd0, q1_reg} * 15'd100;
        rem    = {1'b0, y1_reg} - q_x100;
        leap   = ((rem != 15'd0) && (y1_reg[1:0] == 2'd0))
                 || ((rem == 15'd0) && (q1_reg[1:0] == 2'd0));
        legal_next = 1'b1;
        if (m1_reg < 4'd1 || m1_reg > 4'd12)
        begin
            legal_next = 1'b0;
        end
        if (d1_reg == 5'd0)
        begin
            legal_next = 1'b0;
        end
        if ((m1_reg inside {4'd4, 4'd6, 4'd9, 4'd11}) && d1_reg > 5'd30)
        begin
            legal_next = 1'b0;
        end
        if (m1_reg == 4'd2 && d1_reg > (leap ? 5'd29 : 5'd28))
        begin
            legal_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start;
            done_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            y1_reg <= key[KEY_W-1 -: YEAR_W];
            m1_reg <= key[DAY_W +: MON_W];
            d1_reg <= key[DAY_W-1:0];
            q1_reg <= prod[26:19];
        end
        if (v1_reg)
        begin
            legal_reg <= legal_next;
        end
    end

    assign chk.done  = done_reg;
    assign chk.legal = legal_reg;

endmodule

### sv/date_keyed_sorted_table.sv
// Usage: sorted date-keyed record table with add, show, remove and range list.
// The request channel (req_valid/req_ready) takes one command: kind, a key
// date, a range end date for list and a content handle for add. The response
// channel (rsp_valid/rsp_ready) returns status, record date, handle and last.
// One request is worked on at a time; req_ready is high only when idle.
// Each stored record visited takes a read state, then a compare or write
// state, on the single memory read port. Add is a search pass, then a
// downward shift pass; remove is a search pass, then a shift pass; show is
// a search pass; list scans every stored record, held back by response
// stalls. An illegal date is answered after the date check, with no search.
// The next request is taken from the cycle after the response is loaded.
// Every command yields one response with last set, except list, which yields
// one response per record in range, last set on the final one, or one empty.
// A stalled receiver holds the output register; the list scan waits until
// the pending record can be handed over, and nothing is lost.
// Reset empties the table at once (record count to zero); no clearing pass.
module date_keyed_sorted_table #(
    parameter int ENTRIES     = 32,
    parameter int HANDLE_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_ready,
    input  logic [1:0]                        kind,
    input  logic [dkst_pkg::YEAR_W-1:0]       key_year,
    input  logic [dkst_pkg::MON_W-1:0]        key_month,
    input  logic [dkst_pkg::DAY_W-1:0]        key_day,
    input  logic [dkst_pkg::YEAR_W-1:0]       end_year,
    input  logic [dkst_pkg::MON_W-1:0]        end_month,
    input  logic [dkst_pkg::DAY_W-1:0]        end_day,
    input  logic [dkst_pkg::OUT_HANDLE_W-1:0] content_handle,
    output logic                              rsp_valid,
    input  logic                              rsp_ready,
    output logic [3:0]                        status,
    output logic [dkst_pkg::YEAR_W-1:0]       entry_year,
    output logic [dkst_pkg::MON_W-1:0]        entry_month,
    output logic [dkst_pkg::DAY_W-1:0]        entry_day,
    output logic [dkst_pkg::OUT_HANDLE_W-1:0] entry_handle,
    output logic                              last
);
    import dkst_pkg::*;

`include "date_keyed_sorted_table_assert.svh"

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int MW    = KEY_W + HANDLE_BITS;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b000000000001,
        S_CHECK  = 12'b000000000010,
        S_FRD    = 12'b000000000100,
        S_FCMP   = 12'b000000001000,
        S_FDEC   = 12'b000000010000,
        S_INS_RD = 12'b000000100000,
        S_INS_WR = 12'b000001000000,
        S_DEL_RD = 12'b000010000000,
        S_DEL_WR = 12'b000100000000,
        S_RESP   = 12'b001000000000,
        S_LRD    = 12'b010000000000,
        S_LCMP   = 12'b100000000000
    } state_t;

    state_t                 state_reg, state_next;
    logic                   lend_reg, lend_next;
    logic [1:0]             kind_reg, kind_next;
    logic [KEY_W-1:0]       tgt_reg, tgt_next;
    logic [KEY_W-1:0]       end_reg, end_next;
    logic [HANDLE_BITS-1:0] hin_reg, hin_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [CNT_W-1:0]       i_reg, i_next;
    logic                   hit_reg, hit_next;
    logic                   pend_reg, pend_next;
    logic [KEY_W-1:0]       rec_key_reg, rec_key_next;
    logic [HANDLE_BITS-1:0] rec_h_reg, rec_h_next;
    logic [3:0]             st_reg, st_next;

    logic                   ov_reg;
    logic [3:0]             o_st_reg;
    logic [KEY_W-1:0]       o_key_reg;
    logic [HANDLE_BITS-1:0] o_h_reg;
    logic                   o_last_reg;

    logic                   ld_out;
    logic [3:0]             ld_st;
    logic [KEY_W-1:0]       ld_key;
    logic [HANDLE_BITS-1:0] ld_h;
    logic                   ld_last;

    logic                   mem_we, mem_re;
    logic [IDX_W-1:0]       mem_waddr, mem_raddr;
    logic [MW-1:0]          mem_wdata, mem_rdata;
    logic [KEY_W-1:0]       rk;
    logic [HANDLE_BITS-1:0] rh;

    logic                   chk_start;
    dkst_chk_t              chk;
    logic                   out_free;
    logic [CNT_W-1:0]       i_dec, i_inc;
    logic [HANDLE_BITS+OUT_HANDLE_W-1:0] hin_ext;
    logic [HANDLE_BITS+OUT_HANDLE_W-1:0] hout_ext;
    logic                   accept;
    logic                   we_state;

    dkst_mem #(
        .DEPTH(ENTRIES),
        .WIDTH(MW),
        .AW   (IDX_W)
    ) u_mem (
        .clk  (clk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .re   (mem_re),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    dkst_date_check u_chk (
        .clk  (clk),
        .rst_n(rst_n),
        .start(chk_start),
        .key  (tgt_next),
        .chk  (chk)
    );

    assign rk        = mem_rdata[MW-1:HANDLE_BITS];
    assign rh        = mem_rdata[HANDLE_BITS-1:0];
    assign out_free  = !ov_reg || rsp_ready;
    assign i_dec     = i_reg - 1'b1;
    assign i_inc     = i_reg + 1'b1;
    assign hin_ext   = {{HANDLE_BITS{1'b0}}, content_handle};
    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign we_state  = (state_reg == S_FDEC) || (state_reg == S_INS_RD)
                       || (state_reg == S_INS_WR) || (state_reg == S_DEL_WR);

    always_comb
    begin
        state_next   = state_reg;
        lend_next    = lend_reg;
        kind_next    = kind_reg;
        tgt_next     = tgt_reg;
        end_next     = end_reg;
        hin_next     = hin_reg;
        cnt_next     = cnt_reg;
        i_next       = i_reg;
        hit_next     = hit_reg;
        pend_next    = pend_reg;
        rec_key_next = rec_key_reg;
        rec_h_next   = rec_h_reg;
        st_next      = st_reg;
        ld_out       = 1'b0;
        ld_st        = st_reg;
        ld_key       = rec_key_reg;
        ld_h         = rec_h_reg;
        ld_last      = 1'b1;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_waddr    = i_reg[IDX_W-1:0];
        mem_raddr    = i_reg[IDX_W-1:0];
        mem_wdata    = {tgt_reg, hin_reg};
        chk_start    = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    kind_next = kind;
                    tgt_next  = {key_year, key_month, key_day};
                    end_next  = {end_year, end_month, end_day};
                    hin_next  = hin_ext[HANDLE_BITS-1:0];
                    i_next    = '0;
                    pend_next = 1'b0;
                    lend_next = 1'b0;
                    if (kind == KIND_LIST)
                    begin
                        state_next = S_LRD;
                    end
                    else
                    begin
                        chk_start  = 1'b1;
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if (chk.done)
                begin
                    hit_next = 1'b0;
                    if (chk.legal)
                    begin
                        state_next = S_FRD;
                    end
                    else
                    begin
                        st_next    = ST_ILLEGAL;
                        state_next = S_RESP;
                    end
                end
            end
            S_FRD:
            begin
                if (i_reg == cnt_reg)
                begin
                    state_next = S_FDEC;
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = S_FCMP;
                end
            end
            S_FCMP:
            begin
                if (rk == tgt_reg)
                begin
                    hit_next     = 1'b1;
                    rec_key_next = rk;
                    rec_h_next   = rh;
                    state_next   = S_FDEC;
                end
                else if (rk > tgt_reg)
                begin
                    state_next = S_FDEC;
                end
                else
                begin
                    i_next     = i_inc;
                    state_next = S_FRD;
                end
            end
            S_FDEC:
            begin
                state_next = S_RESP;
                if (kind_reg == KIND_ADD)
                begin
                    if (hit_reg)
                    begin
                        // overwrite the handle in place
                        mem_we       = 1'b1;
                        rec_key_next = tgt_reg;
                        rec_h_next   = hin_reg;
                        st_next      = ST_REPLACED;
                    end
                    else if (cnt_reg == CNT_W'(ENTRIES))
                    begin
                        st_next = ST_FULL;
                    end
                    else
                    begin
                        i_next     = cnt_reg;
                        state_next = S_INS_RD;
                    end
                end
                else if (!hit_reg)
                begin
                    st_next = ST_NOTFOUND;
                end
                else if (kind_reg == KIND_SHOW)
                begin
                    st_next = ST_FOUND;
                end
                else
                begin
                    state_next = S_DEL_RD;
                end
            end
            S_INS_RD:
            begin
                if (i_reg == '0)
                begin
                    mem_we       = 1'b1;
                    cnt_next     = cnt_reg + 1'b1;
                    rec_key_next = tgt_reg;
                    rec_h_next   = hin_reg;
                    st_next      = ST_INSERTED;
                    state_next   = S_RESP;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = i_dec[IDX_W-1:0];
                    state_next = S_INS_WR;
                end
            end
            S_INS_WR:
            begin
                mem_we = 1'b1;
                if (rk > tgt_reg)
                begin
                    // shift the larger record up one place
                    mem_wdata  = mem_rdata;
                    i_next     = i_dec;
                    state_next = S_INS_RD;
                end
                else
                begin
                    cnt_next     = cnt_reg + 1'b1;
                    rec_key_next = tgt_reg;
                    rec_h_next   = hin_reg;
                    st_next      = ST_INSERTED;
                    state_next   = S_RESP;
                end
            end
            S_DEL_RD:
            begin
                if (i_inc == cnt_reg)
                begin
                    cnt_next   = cnt_reg - 1'b1;
                    st_next    = ST_REMOVED;
                    state_next = S_RESP;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = i_inc[IDX_W-1:0];
                    state_next = S_DEL_WR;
                end
            end
            S_DEL_WR:
            begin
                mem_we     = 1'b1;
                mem_wdata  = mem_rdata;
                i_next     = i_inc;
                state_next = S_DEL_RD;
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    ld_out = 1'b1;
                    ld_st  = st_reg;
                    if (st_reg inside {ST_NOTFOUND, ST_ILLEGAL, ST_FULL})
                    begin
                        ld_key = '0;
                        ld_h   = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            S_LRD:
            begin
                if (i_reg == cnt_reg)
                begin
                    lend_next  = 1'b1;
                    state_next = S_LCMP;
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = S_LCMP;
                end
            end
            S_LCMP:
            begin
                if (lend_reg)
                begin
                    // hand over the held record as final, or report empty
                    if (out_free)
                    begin
                        ld_out = 1'b1;
                        if (pend_reg)
                        begin
                            ld_st = ST_ENTRY;
                        end
                        else
                        begin
                            ld_st  = ST_EMPTY;
                            ld_key = '0;
                            ld_h   = '0;
                        end
                        state_next = S_IDLE;
                    end
                end
                else if (rk >= tgt_reg && rk <= end_reg)
                begin
                    if (pend_reg)
                    begin
                        if (out_free)
                        begin
                            ld_out       = 1'b1;
                            ld_st        = ST_ENTRY;
                            ld_last      = 1'b0;
                            rec_key_next = rk;
                            rec_h_next   = rh;
                            i_next       = i_inc;
                            state_next   = S_LRD;
                        end
                    end
                    else
                    begin
                        pend_next    = 1'b1;
                        rec_key_next = rk;
                        rec_h_next   = rh;
                        i_next       = i_inc;
                        state_next   = S_LRD;
                    end
                end
                else
                begin
                    i_next     = i_inc;
                    state_next = S_LRD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
            lend_reg  <= 1'b0;
            pend_reg  <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            lend_reg  <= lend_next;
            pend_reg  <= pend_next;
            hit_reg   <= hit_next;
            if (ld_out)
            begin
                ov_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        tgt_reg     <= tgt_next;
        end_reg     <= end_next;
        hin_reg     <= hin_next;
        i_reg       <= i_next;
        rec_key_reg <= rec_key_next;
        rec_h_reg   <= rec_h_next;
        st_reg      <= st_next;
        if (ld_out)
        begin
            o_st_reg   <= ld_st;
            o_key_reg  <= ld_key;
            o_h_reg    <= ld_h;
            o_last_reg <= ld_last;
        end
    end

    assign hout_ext     = {{OUT_HANDLE_W{1'b0}}, o_h_reg};
    assign rsp_valid    = ov_reg;
    assign status       = o_st_reg;
    assign entry_year   = o_key_reg[KEY_W-1 -: YEAR_W];
    assign entry_month  = o_key_reg[DAY_W +: MON_W];
    assign entry_day    = o_key_reg[DAY_W-1:0];
    assign entry_handle = hout_ext[OUT_HANDLE_W-1:0];
    assign last         = o_last_reg;

    `DKST_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_reg <= CNT_W'(ENTRIES))
    `DKST_ASSERT_NXT(a_accept_busy, accept, state_reg != S_IDLE)
    `DKST_ASSERT_IMP(a_we_states, mem_we, we_state)
    `DKST_ASSERT_IMP(a_load_free, ld_out, !ov_reg || rsp_ready)
    `DKST_ASSERT_NXT(a_cnt_grow, (state_reg == S_INS_RD) && mem_we, cnt_reg == $past(cnt_reg) + 1'b1)

endmodule

### tb/tb_date_keyed_sorted_table.sv
// Self-checking testbench of the date-keyed sorted record table.
`timescale 1ns / 1ps

module tb_date_keyed_sorted_table;
    import dkst_pkg::*;

    localparam int ENTRIES = 32;
    localparam int REQ_COUNT = 200;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [3:0] NO_TYPED = 4'hF;

    typedef struct packed {
        logic [3:0]  st;
        logic [13:0] yr;
        logic [3:0]  mo;
        logic [4:0]  dy;
        logic [15:0] hd;
        logic        lst;
    } rsp_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [13:0] ky;
        logic [3:0]  km;
        logic [4:0]  kd;
        logic [13:0] ey;
        logic [3:0]  em;
        logic [4:0]  ed;
        logic [15:0] hd;
        logic        typed;
        logic [3:0]  want_st;
    } req_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    logic [1:0]  kind = KIND_ADD;
    logic [13:0] key_year = '0;
    logic [3:0]  key_month = '0;
    logic [4:0]  key_day = '0;
    logic [13:0] end_year = '0;
    logic [3:0]  end_month = '0;
    logic [4:0]  end_day = '0;
    logic [15:0] content_handle = '0;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    logic [3:0]  status;
    logic [13:0] entry_year;
    logic [3:0]  entry_month;
    logic [4:0]  entry_day;
    logic [15:0] entry_handle;
    logic        last;

    logic [22:0] tbl_keys[ENTRIES];
    logic [15:0] tbl_handles[ENTRIES];
    int          tbl_count;
    rsp_t        pending_rsp[$];
    logic [3:0]  typed_status[$];
    bit          failed = 1'b0;
    int          cycles = 0;
    int          ready_mode = 0;

    date_keyed_sorted_table dut (.*);

    always #6 clk = ~clk;

    function automatic bit date_legal(logic [13:0] y, logic [3:0] m, logic [4:0] d);
        bit leap;
        leap = ((y % 100) != 0 && (y % 4) == 0) || (y % 400) == 0;
        if (m < 1 || m > 12 || d < 1) return 0;
        if ((m == 4 || m == 6 || m == 9 || m == 11) && d > 30) return 0;
        if (m == 2 && d > (leap ? 29 : 28)) return 0;
        return 1;
    endfunction

    function automatic rsp_t mk(logic [3:0] s, logic [22:0] k, logic [15:0] h, logic l);
        return '{s, k[22:9], k[8:5], k[4:0], h, l};
    endfunction

    // Queue one expected response at the back.
    function automatic void put_rsp(rsp_t x);
        pending_rsp.insert(pending_rsp.size(), x);
    endfunction

    // Apply one request to the table copy and queue its responses.
    function automatic void predict_table(req_t r);
        logic [22:0] k, e;
        int idx, n, total;
        k = {r.ky, r.km, r.kd};
        if (r.op == KIND_LIST)
        begin
            e = {r.ey, r.em, r.ed};
            total = 0;
            for (int i = 0; i < tbl_count; i++)
            begin
                if (tbl_keys[i] >= k && tbl_keys[i] <= e) total++;
            end
            n = 0;
            for (int i = 0; i < tbl_count; i++)
            begin
                if (tbl_keys[i] >= k && tbl_keys[i] <= e)
                begin
                    n++;
                    put_rsp(mk(ST_ENTRY, tbl_keys[i], tbl_handles[i], n == total));
                end
            end
            if (total == 0) put_rsp(mk(ST_EMPTY, '0, '0, 1'b1));
            return;
        end
        if (!date_legal(r.ky, r.km, r.kd))
        begin
            put_rsp(mk(ST_ILLEGAL, '0, '0, 1'b1));
            return;
        end
        if (r.op == KIND_ADD)
        begin
            for (idx = 0; idx < tbl_count; idx++) if (tbl_keys[idx] >= k) break;
            if (idx < tbl_count && tbl_keys[idx] == k)
            begin
                tbl_handles[idx] = r.hd;
                put_rsp(mk(ST_REPLACED, k, r.hd, 1'b1));
            end
            else if (tbl_count >= ENTRIES)
            begin
                put_rsp(mk(ST_FULL, '0, '0, 1'b1));
            end
            else
            begin
                for (int i = tbl_count; i > idx; i--)
                begin
                    tbl_keys[i] = tbl_keys[i-1];
                    tbl_handles[i] = tbl_handles[i-1];
                end
                tbl_keys[idx] = k;
                tbl_handles[idx] = r.hd;
                tbl_count++;
                put_rsp(mk(ST_INSERTED, k, r.hd, 1'b1));
            end
            return;
        end
        for (idx = 0; idx < tbl_count; idx++) if (tbl_keys[idx] == k) break;
        if (idx == tbl_count)
        begin
            put_rsp(mk(ST_NOTFOUND, '0, '0, 1'b1));
        end
        else if (r.op == KIND_SHOW)
        begin
            put_rsp(mk(ST_FOUND, k, tbl_handles[idx], 1'b1));
        end
        else
        begin
            put_rsp(mk(ST_REMOVED, k, tbl_handles[idx], 1'b1));
            for (int i = idx; i + 1 < tbl_count; i++)
            begin
                tbl_keys[i] = tbl_keys[i+1];
                tbl_handles[i] = tbl_handles[i+1];
            end
            tbl_count--;
        end
    endfunction

    // Hold the request until taken; the caller drops valid when a gap follows.
    task automatic send_request(req_t r);
        kind <= r.op;
        key_year <= r.ky;
        key_month <= r.km;
        key_day <= r.kd;
        end_year <= r.ey;
        end_month <= r.em;
        end_day <= r.ed;
        content_handle <= r.hd;
        req_valid <= 1'b1;
        do @(posedge clk); while (!req_ready);
        predict_table(r);
        typed_status.insert(typed_status.size(), r.typed ? r.want_st : NO_TYPED);
        @(negedge clk);
    endtask

    function automatic req_t rnd_req(logic [1:0] op, bit legal);
        req_t r;
        r = '0;
        r.op = op;
        // A small date pool keeps hits, replacements and a full table likely.
        if (legal)
        begin
            r.ky = 14'(1998 + $urandom_range(0, 3) * ($urandom_range(0, 7) == 0 ? 2000 : 1));
            r.km = 4'($urandom_range(1, 12));
            r.kd = 5'($urandom_range(1, 28));
            if ($urandom_range(0, 3) == 0) r.kd = 5'($urandom_range(1, 31));
        end
        else
        begin
            r.ky = 14'($urandom);
            r.km = 4'($urandom);
            r.kd = 5'($urandom);
        end
        r.ey = r.ky + 14'($urandom_range(0, 3));
        r.em = 4'($urandom_range(0, 15));
        r.ed = 5'($urandom);
        if ($urandom_range(0, 7) == 0) r.ey = 14'($urandom);
        r.hd = 16'($urandom);
        return r;
    endfunction

    // Directed table: operation, key, range end, handle, typed status.
    req_t directed[$] = '{
        '{KIND_SHOW,   14'd2000, 4'd1,  5'd1,  14'd0, 4'd0, 5'd0, 16'h0, 1'b1, ST_NOTFOUND},
        '{KIND_LIST,   14'd0,    4'd0,  5'd0,  14'h3FFF, 4'hF, 5'h1F, 16'h0, 1'b1, ST_EMPTY},
        '{KIND_ADD,    14'd2000, 4'd2,  5'd29, 14'd0, 4'd0, 5'd0, 16'hFFFF, 1'b1, ST_INSERTED},
        '{KIND_ADD,    14'd1900, 4'd2,  5'd29, 14'd0, 4'd0, 5'd0, 16'h1, 1'b1, ST_ILLEGAL},
        '{KIND_ADD,    14'd0,    4'd2,  5'd29, 14'd0, 4'd0, 5'd0, 16'h2, 1'b1, ST_INSERTED},
        '{KIND_ADD,    14'd2004, 4'd2,  5'd29, 14'd0, 4'd0, 5'd0, 16'h3, 1'b0, 4'd0},
        '{KIND_ADD,    14'd2001, 4'd2,  5'd29, 14'd0, 4'd0, 5'd0, 16'h4, 1'b1, ST_ILLEGAL},
        '{KIND_ADD,    14'd2001, 4'd4,  5'd31, 14'd0, 4'd0, 5'd0, 16'h5, 1'b1, ST_ILLEGAL},
        '{KIND_ADD,    14'd2001, 4'd13, 5'd1,  14'd0, 4'd0, 5'd0, 16'h6, 1'b1, ST_ILLEGAL},
        '{KIND_ADD,    14'd2001, 4'd0,  5'd1,  14'd0, 4'd0, 5'd0, 16'h7, 1'b1, ST_ILLEGAL},
        '{KIND_ADD,    14'd2001, 4'd1,  5'd0,  14'd0, 4'd0, 5'd0, 16'h8, 1'b1, ST_ILLEGAL},
        '{KIND_ADD,    14'h3FFF, 4'd12, 5'd31, 14'd0, 4'd0, 5'd0, 16'h5A5A, 1'b0, 4'd0},
        '{KIND_ADD,    14'd2000, 4'd2,  5'd29, 14'd0, 4'd0, 5'd0, 16'h1234, 1'b0, 4'd0},
        '{KIND_SHOW,   14'd2000, 4'd2,  5'd29, 14'd0, 4'd0, 5'd0, 16'h0, 1'b0, 4'd0},
        '{KIND_SHOW,   14'd2000, 4'd2,  5'd30, 14'd0, 4'd0, 5'd0, 16'h0, 1'b1, ST_ILLEGAL},
        '{KIND_LIST,   14'd0,    4'd0,  5'd0,  14'h3FFF, 4'hF, 5'h1F, 16'h0, 1'b0, 4'd0},
        '{KIND_LIST,   14'd2004, 4'd0,  5'd0,  14'd1999, 4'd0, 5'd0, 16'h0, 1'b1, ST_EMPTY},
        '{KIND_LIST,   14'd2000, 4'd2,  5'd29, 14'd2000, 4'd2, 5'd29, 16'h0, 1'b0, 4'd0},
        '{KIND_REMOVE, 14'd2000, 4'd2,  5'd29, 14'd0, 4'd0, 5'd0, 16'h0, 1'b0, 4'd0},
        '{KIND_REMOVE, 14'd2000, 4'd2,  5'd29, 14'd0, 4'd0, 5'd0, 16'h0, 1'b1, ST_NOTFOUND},
        '{KIND_REMOVE, 14'd2000, 4'd15, 5'd31, 14'd0, 4'd0, 5'd0, 16'h0, 1'b1, ST_ILLEGAL}
    };

    // Receiver: stall on a pattern that changes mode now and then.
    always @(negedge clk)
    begin
        if ($urandom_range(0, 63) == 0) ready_mode <= $urandom_range(0, 3);
        case (ready_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 3) != 0);
            2: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= (cycles % 8) < 5;
        endcase
    end

    always @(posedge clk)
    begin
        rsp_t exp_r;
        logic [3:0] want;
        cycles <= cycles + 1;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                $error("response with none expected: status %0d", status);
                failed = 1'b1;
            end
            else
            begin
                exp_r = pending_rsp.pop_front();
                // Check the typed status of a directed row on its final response.
                if (exp_r.lst && typed_status.size() != 0)
                begin
                    want = typed_status.pop_front();
                    if (want != NO_TYPED && status !== want)
                    begin
                        $error("status: expected %0d, got %0d", want, status);
                        failed = 1'b1;
                    end
                end
                if (status !== exp_r.st)
                begin
                    $error("status: expected %0d, got %0d", exp_r.st, status);
                    failed = 1'b1;
                end
                if (entry_year !== exp_r.yr)
                begin
                    $error("entry_year: expected %0d, got %0d", exp_r.yr, entry_year);
                    failed = 1'b1;
                end
                if (entry_month !== exp_r.mo)
                begin
                    $error("entry_month: expected %0d, got %0d", exp_r.mo, entry_month);
                    failed = 1'b1;
                end
                if (entry_day !== exp_r.dy)
                begin
                    $error("entry_day: expected %0d, got %0d", exp_r.dy, entry_day);
                    failed = 1'b1;
                end
                if (entry_handle !== exp_r.hd)
                begin
                    $error("entry_handle: expected %0h, got %0h", exp_r.hd, entry_handle);
                    failed = 1'b1;
                end
                if (last !== exp_r.lst)
                begin
                    $error("last: expected %0d, got %0d", exp_r.lst, last);
                    failed = 1'b1;
                end
            end
        end
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        req_t r;
        int burst, gap, pick;
        bit drained;
        tbl_count = 0;
        drained = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        foreach (directed[i])
        begin
            send_request(directed[i]);
        end
        // Drop valid and wait for every directed response.
        req_valid <= 1'b0;
        wait (pending_rsp.size() == 0);
        @(negedge clk);
        for (int n = 0; n < REQ_COUNT; )
        begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst && n < REQ_COUNT; b++, n++)
            begin
                pick = $urandom_range(0, 99);
                // Weight toward adds to fill the table hard, mixed with lookups, removals and lists.
                if (pick < 45) r = rnd_req(KIND_ADD, $urandom_range(0, 9) != 0);
                else if (pick < 60) r = rnd_req(KIND_LIST, 1);
                else if (pick < 80) r = rnd_req(KIND_SHOW, $urandom_range(0, 9) != 0);
                else r = rnd_req(KIND_REMOVE, $urandom_range(0, 9) != 0);
                if (r.op == KIND_LIST && $urandom_range(0, 4) == 0)
                begin
                    r.ky = '0; r.km = '0; r.kd = '0;
                    r.ey = 14'h3FFF; r.em = 4'hF; r.ed = 5'h1F;
                end
                send_request(r);
            end
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
            if (!drained && n >= REQ_COUNT / 2)
            begin
                // Pause until everything sent has been answered.
                req_valid <= 1'b0;
                wait (pending_rsp.size() == 0);
                @(negedge clk);
                drained = 1'b1;
            end
            else if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        req_valid <= 1'b0;
        wait (pending_rsp.size() == 0);
        repeat (300) @(posedge clk);
        if (!failed && pending_rsp.size() == 0 && typed_status.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
